FILE: rtl/rcl_pkg.sv
// shared constants and types for the rgb tone curve lookup block
// no dependencies; imported by rgb_curve_lut_interpolator
`default_nettype none

package rcl_pkg;

	// curve geometry: TABLE_STEPS must be even (entries split into even and odd banks)
	localparam int TABLE_STEPS = 256;
	localparam int CH_N        = 3;

	// item field widths
	localparam int ACTION_W = 1;
	localparam int CHSEL_W  = 2;
	localparam int ENTRY_W  = 9;
	localparam int VALUE_W  = 16;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 8;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// arithmetic widths
	localparam int FRAC_W  = 28;
	localparam int PROD_W  = SAMPLE_W + CFG_W;
	localparam int POS_W   = PROD_W + 1;
	localparam int IDX_W   = $clog2(TABLE_STEPS);
	localparam int DIFF_W  = VALUE_W + 1;
	localparam int MUL_W   = DIFF_W + FRAC_W + 1;
	localparam int Y_W     = MUL_W + 1;
	localparam int Y_FRAC  = FRAC_W + 12;
	localparam int SCL_W   = Y_FRAC + OUT_W;

	// even bank holds entries 0,2,..,TABLE_STEPS; odd bank holds 1,3,..
	localparam int EVEN_DEPTH = TABLE_STEPS / 2 + 1;
	localparam int ODD_DEPTH  = TABLE_STEPS / 2;
	localparam int EVEN_AW    = $clog2(EVEN_DEPTH);
	localparam int ODD_AW     = $clog2(ODD_DEPTH);

	localparam logic signed [POS_W-1:0] POS_LIMIT =
		POS_W'(TABLE_STEPS) <<< FRAC_W;
	localparam logic signed [Y_W-1:0] Y_ONE = Y_W'(64'sd4096 <<< FRAC_W);
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [CFG_W-1:0] SCALE_RESET  = 32'd16777216;
	localparam logic [CFG_W-1:0] OFFSET_RESET = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_SCALE    = 3'd0,
		REG_GREEN_SCALE  = 3'd1,
		REG_BLUE_SCALE   = 3'd2,
		REG_RED_OFFSET   = 3'd3,
		REG_GREEN_OFFSET = 3'd4,
		REG_BLUE_OFFSET  = 3'd5
	} cfg_reg_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [VALUE_W-1:0]  entry_t;

endpackage

`default_nettype wire

FILE: rtl/rgb_curve_lut_interpolator.sv
// per-channel rgb tone curve with linear interpolation between table entries
// depends on rcl_pkg; curve tables live in even/odd entry banks per channel
// a pixel item passes stages 1 to 5 and the output register before it shows on m_tvalid
// throughput: one item (pixel or table load) per clock; a stage stalls only when the next is full
// table loads write their bank in the stage where pixels read, so order holds without forwarding
// reset clears valid bits and offsets, sets scales to SCALE_RESET; tables undefined until loaded
`default_nettype none

module rgb_curve_lut_interpolator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// table load / pixel items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// tdata from bit 0: table_channel, entry_index, entry_value, red_in, green_in,
	// blue_in, zero padding
	input  wire logic [rcl_pkg::IN_DATA_W-1:0] s_tdata,
	// tuser: action
	input  wire logic [rcl_pkg::ACTION_W-1:0]  s_tuser,
	// mapped pixels
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// tdata from bit 0: red_out, green_out, blue_out
	output logic [rcl_pkg::OUT_DATA_W-1:0]     m_tdata,
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcl_pkg::CFG_W-1:0]     cfg_data
);
	import rcl_pkg::*;

	// configuration
	logic [CFG_W-1:0] scale_q  [CH_N];
	logic [CFG_W-1:0] offset_q [CH_N];

	// stage enables and valid bits
	logic en1, en2, en3, en4, en5, en_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;

	// unpacked input item
	action_t              in_action;
	logic [CHSEL_W-1:0]   in_chan;
	logic [ENTRY_W-1:0]   in_entry;
	entry_t               in_value;
	sample_t              in_sample [CH_N];

	// load fields travel with the item up to the bank write stage
	action_t              act_s1, act_s2;
	logic [CHSEL_W-1:0]   chan_s1, chan_s2;
	logic [ENTRY_W-1:0]   entry_s1, entry_s2;
	entry_t               value_s1, value_s2;
	logic                 load_ok_s2;

	// per-channel datapath
	logic signed [PROD_W-1:0] prod_s1   [CH_N];
	logic signed [POS_W-1:0]  pos       [CH_N];
	logic [IDX_W-1:0]         idx_s2    [CH_N];
	logic [FRAC_W-1:0]        frac_s2   [CH_N];
	logic                     hi_s2     [CH_N];
	entry_t                   even_rd_s3 [CH_N];
	entry_t                   odd_rd_s3  [CH_N];
	logic                     par_s3    [CH_N];
	logic                     hi_s3     [CH_N];
	logic [FRAC_W-1:0]        frac_s3   [CH_N];
	entry_t                   base_s4   [CH_N];
	logic signed [MUL_W-1:0]  mul_s4    [CH_N];
	logic signed [Y_W-1:0]    y_s5      [CH_N];
	logic [OUT_W-1:0]         code      [CH_N];
	logic [OUT_W-1:0]         out_q     [CH_N];

	// curve banks, undefined until loaded
	entry_t even_mem [CH_N][EVEN_DEPTH];
	entry_t odd_mem  [CH_N][ODD_DEPTH];

	assign in_action = action_t'(s_tuser);
	assign in_chan   = s_tdata[1:0];
	assign in_entry  = s_tdata[10:2];
	assign in_value  = s_tdata[26:11];
	assign in_sample[0] = s_tdata[42:27];
	assign in_sample[1] = s_tdata[58:43];
	assign in_sample[2] = s_tdata[74:59];

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH_N; c++) begin
				scale_q[c]  <= SCALE_RESET;
				offset_q[c] <= OFFSET_RESET;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RED_SCALE:    scale_q[0]  <= cfg_data;
				REG_GREEN_SCALE:  scale_q[1]  <= cfg_data;
				REG_BLUE_SCALE:   scale_q[2]  <= cfg_data;
				REG_RED_OFFSET:   offset_q[0] <= cfg_data;
				REG_GREEN_OFFSET: offset_q[1] <= cfg_data;
				REG_BLUE_OFFSET:  offset_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		en_out = !out_valid_q || m_tready;
		en5    = !v_s5 || en_out;
		en4    = !v_s4 || en5;
		en3    = !v_s3 || en4;
		en2    = !v_s2 || en3;
		en1    = !v_s1 || en2;
	end

	assign s_tready = en1;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v_s1 <= s_tvalid;
			if (en2)    v_s2 <= v_s1;
			// load items end at the bank write stage
			if (en3)    v_s3 <= v_s2 && (act_s2 == ACT_PIXEL);
			if (en4)    v_s4 <= v_s3;
			if (en5)    v_s5 <= v_s4;
			if (en_out) out_valid_q <= v_s5;
		end
	end

	// item control payload
	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1   <= in_action;
			chan_s1  <= in_chan;
			entry_s1 <= in_entry;
			value_s1 <= in_value;
		end
		if (en2) begin
			act_s2   <= act_s1;
			chan_s2  <= chan_s1;
			entry_s2 <= entry_s1;
			value_s2 <= value_s1;
		end
	end

	// loads beyond the last entry or to the unused channel code are dropped
	assign load_ok_s2 = v_s2 && (act_s2 == ACT_LOAD) &&
		(entry_s2 <= ENTRY_W'(TABLE_STEPS)) && (chan_s2 < CHSEL_W'(CH_N));

	for (genvar c = 0; c < CH_N; c++) begin : g_ch
		logic                    neg;
		logic                    hi;
		logic [EVEN_AW-1:0]      rd_even_addr;
		logic [ODD_AW-1:0]       rd_odd_addr;
		logic                    rd_en;
		logic                    we;
		entry_t                  a_val;
		entry_t                  b_val;
		logic signed [DIFF_W-1:0] diff;

		// stage 1: sample times scale, q.28 position before offset
		always_ff @(posedge clk) begin
			if (en1) begin
				prod_s1[c] <= PROD_W'(in_sample[c] * $signed(scale_q[c]));
			end
		end

		// stage 2: subtract offset, split into entry index and fraction, clamp ends
		always_comb begin
			pos[c] = POS_W'(prod_s1[c]) - (POS_W'($signed(offset_q[c])) <<< 12);
			neg    = pos[c][POS_W-1];
			hi     = !neg && (pos[c] >= POS_LIMIT);
		end

		always_ff @(posedge clk) begin
			if (en2) begin
				hi_s2[c] <= hi;
				if (neg) begin
					idx_s2[c]  <= '0;
					frac_s2[c] <= '0;
				end else if (hi) begin
					// last pair, upper entry taken whole
					idx_s2[c]  <= IDX_W'(TABLE_STEPS - 1);
					frac_s2[c] <= '0;
				end else begin
					idx_s2[c]  <= pos[c][FRAC_W +: IDX_W];
					frac_s2[c] <= pos[c][FRAC_W-1:0];
				end
			end
		end

		// stage 3: bank access; entry i and i+1 always sit in different banks
		assign rd_odd_addr  = ODD_AW'(idx_s2[c] >> 1);
		assign rd_even_addr = EVEN_AW'(idx_s2[c] >> 1) + EVEN_AW'(idx_s2[c][0]);
		assign rd_en = en3 && v_s2 && (act_s2 == ACT_PIXEL);
		assign we    = en3 && load_ok_s2 && (chan_s2 == CHSEL_W'(c));

		always_ff @(posedge clk) begin
			if (we && !entry_s2[0]) begin
				even_mem[c][EVEN_AW'(entry_s2 >> 1)] <= value_s2;
			end
			if (we && entry_s2[0]) begin
				odd_mem[c][ODD_AW'(entry_s2 >> 1)] <= value_s2;
			end
			if (rd_en) begin
				even_rd_s3[c] <= even_mem[c][rd_even_addr];
				odd_rd_s3[c]  <= odd_mem[c][rd_odd_addr];
			end
		end

		always_ff @(posedge clk) begin
			if (en3) begin
				par_s3[c]  <= idx_s2[c][0];
				hi_s3[c]   <= hi_s2[c];
				frac_s3[c] <= frac_s2[c];
			end
		end

		// stage 4: difference times fraction; clamped ends use one entry only
		always_comb begin
			a_val = par_s3[c] ? odd_rd_s3[c]  : even_rd_s3[c];
			b_val = par_s3[c] ? even_rd_s3[c] : odd_rd_s3[c];
			if (hi_s3[c] || (frac_s3[c] == '0)) begin
				diff = '0;
			end else begin
				diff = DIFF_W'(b_val) - DIFF_W'(a_val);
			end
		end

		always_ff @(posedge clk) begin
			if (en4) begin
				base_s4[c] <= hi_s3[c] ? b_val : a_val;
				mul_s4[c]  <= MUL_W'(diff * $signed({1'b0, frac_s3[c]}));
			end
		end

		// stage 5: curve value in signed q7.40
		always_ff @(posedge clk) begin
			if (en5) begin
				y_s5[c] <= (Y_W'(base_s4[c]) <<< FRAC_W) + Y_W'(mul_s4[c]);
			end
		end

		// output: saturate to 0..1 and scale by 255, truncating
		always_comb begin
			logic [SCL_W-1:0] scaled;
			scaled = ({y_s5[c][Y_FRAC-1:0], OUT_W'(0)}) - SCL_W'(y_s5[c][Y_FRAC-1:0]);
			if (y_s5[c] <= 0) begin
				code[c] = '0;
			end else if (y_s5[c] >= Y_ONE) begin
				code[c] = OUT_MAX;
			end else begin
				code[c] = scaled[SCL_W-1 -: OUT_W];
			end
		end

		always_ff @(posedge clk) begin
			if (en_out) begin
				out_q[c] <= code[c];
			end
		end

		assign m_tdata[c*OUT_W +: OUT_W] = out_q[c];
	end

	// a non-positive red curve value leaves as black
	a_red_floor: assert property (@(posedge clk) disable iff (!arst_n)
		en_out && v_s5 && (y_s5[0] <= 0) |=> m_tdata[OUT_W-1:0] == '0)
		else $error("red code not zero for non-positive curve value");

	// a blue curve value of one or more leaves as full scale
	a_blue_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		en_out && v_s5 && (y_s5[2] >= Y_ONE) |=> m_tdata[3*OUT_W-1 -: OUT_W] == OUT_MAX)
		else $error("blue code not saturated for curve value at or above one");

	// a clamped high green position carries no fraction into the interpolation
	a_hi_no_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && hi_s2[1] |-> frac_s2[1] == '0)
		else $error("green clamped position kept a fraction");

	// a full pipe behind a stalled output takes no new item
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid_q && !m_tready |-> !s_tready)
		else $error("item accepted while every stage is held");

endmodule

`default_nettype wire
